[design/barc_pkg.sv]
// Shared types, constants and arithmetic helpers for the barometer compensation block.
// Used by barc_div and barometer_raw_compensation; depends on nothing else.
`timescale 1ns / 1ps

package barc_pkg;

   localparam int unsigned CSR_WIDTH = 48;
   localparam int unsigned DIV_STEPS = 64;

   localparam logic [31:0] FINE_OFFSET = 32'd128000;
   localparam logic [20:0] RAW_FULL    = 21'd1048576;
   localparam logic [63:0] PRESS_SCALE = 64'd3125;
   localparam logic [31:0] ROUND_HALF  = 32'd128;
   localparam int unsigned ONE_SHIFT   = 47;
   localparam int unsigned P1_SHIFT    = 33;

   typedef enum logic [1:0] {
      CSR_TEMP    = 2'd0,
      CSR_PRESS_A = 2'd1,
      CSR_PRESS_B = 2'd2,
      CSR_PRESS_C = 2'd3
   } csr_index_type;

   // Partial products of a 64 by 64 product, low 64 bits only.
   typedef struct packed {
      logic [63:0] lo;
      logic [31:0] mid_a;
      logic [31:0] mid_b;
   } pp_type;

   // Values that ride along with an item through the pressure path.
   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
      logic        zero;
      logic        neg;
   } side_type;

   function automatic pp_type mul_pp(input logic [63:0] a, input logic [63:0] b);
      pp_type r;
      logic [63:0] lo;
      lo = a[31:0] * b[31:0];
      r.lo    = lo;
      r.mid_a = a[31:0] * b[63:32];
      r.mid_b = a[63:32] * b[31:0];
      return r;
   endfunction

   function automatic logic [63:0] mul_sum(input pp_type p);
      logic [31:0] mid;
      mid = p.mid_a + p.mid_b;
      return p.lo + {mid, 32'd0};
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
      logic signed [63:0] xs;
      xs = x;
      return 64'(xs >>> n);
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
      logic signed [31:0] xs;
      xs = x;
      return 32'(xs >>> n);
   endfunction

   function automatic logic [63:0] sext16(input logic [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

endpackage

[design/barc_div.sv]
// Pipelined unsigned 64 by 64 restoring divider, one quotient bit per stage.
// Depends on barc_pkg for the step count and the sideband type.
`timescale 1ns / 1ps

module barc_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [63:0]         in_dividend,
   input  logic [63:0]         in_divisor,
   input  barc_pkg::side_type  in_side,
   output logic                out_valid,
   output logic [63:0]         out_quotient,
   output barc_pkg::side_type  out_side
);
   import barc_pkg::*;

   logic [63:0] rem_ff  [DIV_STEPS];
   logic [63:0] aq_ff   [DIV_STEPS];
   logic [63:0] mb_ff   [DIV_STEPS];
   side_type    side_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] vld_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [63:0] rem_src, aq_src, mb_src;
      side_type    side_src;
      logic        vld_src;
      logic [64:0] trial;
      logic        fits;

      if (k == 0) begin : g_first
         assign rem_src  = 64'd0;
         assign aq_src   = in_dividend;
         assign mb_src   = in_divisor;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_rest
         assign rem_src  = rem_ff[k-1];
         assign aq_src   = aq_ff[k-1];
         assign mb_src   = mb_ff[k-1];
         assign side_src = side_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      assign trial = {rem_src, aq_src[63]} - {1'b0, mb_src};
      assign fits  = ~trial[64];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= fits ? trial[63:0] : {rem_src[62:0], aq_src[63]};
            aq_ff[k]   <= {aq_src[62:0], fits};
            mb_ff[k]   <= mb_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid    = vld_ff[DIV_STEPS-1];
   assign out_quotient = aq_ff[DIV_STEPS-1];
   assign out_side     = side_ff[DIV_STEPS-1];

endmodule

[design/barometer_raw_compensation.sv]
// Top level of the barometer raw-reading compensation pipeline.
// Depends on barc_pkg and instantiates the pipelined divider barc_div.
`timescale 1ns / 1ps

// The block takes one raw pressure and raw temperature pair per item and
// returns the fine temperature, the temperature in hundredths of a degree and
// the pressure in Q24.8 pascal, all wrapping exactly like the 32-bit and
// 64-bit integer trimming formulas. It accepts one item every cycle while
// req_stall is low. Each item passes 13 stages that build the temperature
// and the pressure dividend and divisor, the 64-stage divider that produces
// one quotient bit per stage, and 7 more stages that finish the pressure
// and hold the result. The whole pipeline moves together; when a result is
// held by rsp_stall, req_stall rises in the same cycle. When the pressure
// divisor is zero, the pressure reads 0 and rsp_divisor_zero is set, while
// the temperature fields are still valid. Write the four trim registers only
// while no item is in flight.
module barometer_raw_compensation (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  barc_pkg::csr_index_type csr_index,
   input  logic [47:0]             csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [19:0]             req_raw_pressure,
   input  logic [19:0]             req_raw_temperature,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_temperature_centi,
   output logic [31:0]             rsp_pressure_q24_8,
   output logic signed [31:0]      rsp_fine_temperature,
   output logic                    rsp_divisor_zero
);
   import barc_pkg::*;

   // Trim registers.
   logic [CSR_WIDTH-1:0] temp_ff, press_a_ff, press_b_ff, press_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff    <= '0;
         press_a_ff <= '0;
         press_b_ff <= '0;
         press_c_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TEMP:    temp_ff    <= csr_write_data;
            CSR_PRESS_A: press_a_ff <= csr_write_data;
            CSR_PRESS_B: press_b_ff <= csr_write_data;
            CSR_PRESS_C: press_c_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Unpacked trim words, sign- or zero-extended to the width they are used at.
   logic [15:0] t1_w;
   logic [31:0] t2_w, t3_w;
   logic [63:0] p1_w, p2_w, p3_w, p4_w, p5_w, p6_w, p7_w, p8_w, p9_w;

   assign t1_w = temp_ff[15:0];
   assign t2_w = {{16{temp_ff[31]}}, temp_ff[31:16]};
   assign t3_w = {{16{temp_ff[47]}}, temp_ff[47:32]};
   assign p1_w = {48'd0, press_a_ff[15:0]};
   assign p2_w = sext16(press_a_ff[31:16]);
   assign p3_w = sext16(press_a_ff[47:32]);
   assign p4_w = sext16(press_b_ff[15:0]);
   assign p5_w = sext16(press_b_ff[31:16]);
   assign p6_w = sext16(press_b_ff[47:32]);
   assign p7_w = sext16(press_c_ff[15:0]);
   assign p8_w = sext16(press_c_ff[31:16]);
   assign p9_w = sext16(press_c_ff[47:32]);

   // The whole pipeline advances unless a finished result is being held.
   logic adv;
   logic rsp_valid_ff;
   assign adv       = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~adv;

   // Front end: temperature path and pressure dividend and divisor.
   logic [13:1] pre_vld_ff;
   logic [31:0] a_w, d_w;
   logic [19:0] adcp_ff [1:4];
   logic [31:0] s1_pa_ff, s1_dd_ff;
   logic [31:0] s2_v1_ff, s2_pc_ff;
   logic [31:0] s3_fine_ff;
   side_type    side_ff [4:13];
   logic [63:0] s4_x_ff;
   logic [20:0] p0_ff [5:9];
   pp_type      s5_xx_ff, s5_x5_ff, s5_x2_ff;
   logic [63:0] s6_x2_ff;
   logic [63:0] xp5_ff [6:8];
   logic [63:0] xp2_ff [6:8];
   pp_type      s7_p6_ff, s7_p3_ff;
   logic [63:0] s8_p6_ff, s8_p3_ff;
   logic [63:0] s9_w2_ff, s9_a1_ff;
   pp_type      s10_a1_ff;
   logic [63:0] s10_num_ff;
   logic [63:0] s11_a1p1_ff;
   pp_type      s11_num_ff;
   logic [63:0] s12_div_ff, s12_num_ff;
   logic [63:0] s13_ma_ff, s13_mb_ff;
   logic        s13_zero_in;

   assign a_w = {15'd0, req_raw_temperature[19:3]} - {15'd0, t1_w, 1'b0};
   assign d_w = {16'd0, req_raw_temperature[19:4]} - {16'd0, t1_w};
   assign s13_zero_in = (s12_div_ff == 64'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else if (adv) begin
         pre_vld_ff <= {pre_vld_ff[12:1], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // Stage 1: the two temperature products.
         s1_pa_ff   <= a_w * t2_w;
         s1_dd_ff   <= d_w * d_w;
         adcp_ff[1] <= req_raw_pressure;
         // Stage 2.
         s2_v1_ff   <= asr32(s1_pa_ff, 11);
         s2_pc_ff   <= asr32(s1_dd_ff, 12) * t3_w;
         adcp_ff[2] <= adcp_ff[1];
         // Stage 3: fine temperature.
         s3_fine_ff <= s2_v1_ff + asr32(s2_pc_ff, 14);
         adcp_ff[3] <= adcp_ff[2];
         // Stage 4: temperature in hundredths and the offset fine value.
         side_ff[4].temp <= asr32(s3_fine_ff * 32'd5 + ROUND_HALF, 8);
         side_ff[4].fine <= s3_fine_ff;
         side_ff[4].zero <= 1'b0;
         side_ff[4].neg  <= 1'b0;
         s4_x_ff    <= {{32{s3_fine_ff[31]}}, s3_fine_ff} - {32'd0, FINE_OFFSET};
         adcp_ff[4] <= adcp_ff[3];
         // Stage 5: products of the offset fine value.
         s5_xx_ff <= mul_pp(s4_x_ff, s4_x_ff);
         s5_x5_ff <= mul_pp(s4_x_ff, p5_w);
         s5_x2_ff <= mul_pp(s4_x_ff, p2_w);
         p0_ff[5] <= RAW_FULL - {1'b0, adcp_ff[4]};
         // Stage 6.
         s6_x2_ff  <= mul_sum(s5_xx_ff);
         xp5_ff[6] <= mul_sum(s5_x5_ff);
         xp2_ff[6] <= mul_sum(s5_x2_ff);
         p0_ff[6]  <= p0_ff[5];
         // Stage 7: square terms.
         s7_p6_ff  <= mul_pp(s6_x2_ff, p6_w);
         s7_p3_ff  <= mul_pp(s6_x2_ff, p3_w);
         xp5_ff[7] <= xp5_ff[6];
         xp2_ff[7] <= xp2_ff[6];
         p0_ff[7]  <= p0_ff[6];
         // Stage 8.
         s8_p6_ff  <= mul_sum(s7_p6_ff);
         s8_p3_ff  <= mul_sum(s7_p3_ff);
         xp5_ff[8] <= xp5_ff[7];
         xp2_ff[8] <= xp2_ff[7];
         p0_ff[8]  <= p0_ff[7];
         // Stage 9: offset sum and divisor sum.
         s9_w2_ff <= s8_p6_ff + (xp5_ff[8] << 17) + (p4_w << 35);
         s9_a1_ff <= (64'd1 << ONE_SHIFT) + asr64(s8_p3_ff, 8) + (xp2_ff[8] << 12);
         p0_ff[9] <= p0_ff[8];
         // Stage 10.
         s10_a1_ff  <= mul_pp(s9_a1_ff, p1_w);
         s10_num_ff <= ({43'd0, p0_ff[9]} << 31) - s9_w2_ff;
         // Stage 11.
         s11_a1p1_ff <= mul_sum(s10_a1_ff);
         s11_num_ff  <= mul_pp(s10_num_ff, PRESS_SCALE);
         // Stage 12: divisor and dividend.
         s12_div_ff <= asr64(s11_a1p1_ff, P1_SHIFT);
         s12_num_ff <= mul_sum(s11_num_ff);
         // Stage 13: magnitudes and quotient sign for the divider.
         s13_ma_ff <= s12_num_ff[63] ? (64'd0 - s12_num_ff) : s12_num_ff;
         s13_mb_ff <= s12_div_ff[63] ? (64'd0 - s12_div_ff) : s12_div_ff;
         for (int k = 5; k <= 12; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         side_ff[13] <= {side_ff[12].temp, side_ff[12].fine, s13_zero_in,
                         s12_num_ff[63] ^ s12_div_ff[63]};
      end
   end

   // Divider.
   logic        div_vld;
   logic [63:0] div_q;
   side_type    div_side;

   barc_div u_div (
      .clock        (clock),
      .reset        (reset),
      .enable       (adv),
      .in_valid     (pre_vld_ff[13]),
      .in_dividend  (s13_ma_ff),
      .in_divisor   (s13_mb_ff),
      .in_side      (side_ff[13]),
      .out_valid    (div_vld),
      .out_quotient (div_q),
      .out_side     (div_side)
   );

   // Back end: the second-order pressure correction.
   logic [6:1]  post_vld_ff;
   side_type    pside_ff [1:6];
   logic [63:0] p_ff [1:5];
   logic [63:0] ps_ff [2:3];
   pp_type      d2_m1_ff, d2_w_ff;
   logic [63:0] d3_m1_ff, d3_w_ff;
   pp_type      d4_m2_ff;
   logic [63:0] w2s_ff [4:5];
   logic [63:0] d5_m2_ff;
   logic [63:0] d6_sum_ff;
   logic [63:0] pout_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         post_vld_ff  <= {post_vld_ff[5:1], div_vld};
         rsp_valid_ff <= post_vld_ff[6];
      end
   end

   assign pout_w = asr64(d6_sum_ff, 8) + (p7_w << 4);

   logic [31:0] rsp_temp_ff, rsp_press_ff, rsp_fine_ff;
   logic        rsp_zero_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         // Signed quotient.
         p_ff[1]     <= div_side.neg ? (64'd0 - div_q) : div_q;
         pside_ff[1] <= div_side;
         // Products of the pressure estimate.
         ps_ff[2] <= asr64(p_ff[1], 13);
         d2_m1_ff <= mul_pp(p9_w, asr64(p_ff[1], 13));
         d2_w_ff  <= mul_pp(p8_w, p_ff[1]);
         p_ff[2]  <= p_ff[1];
         d3_m1_ff <= mul_sum(d2_m1_ff);
         d3_w_ff  <= mul_sum(d2_w_ff);
         ps_ff[3] <= ps_ff[2];
         p_ff[3]  <= p_ff[2];
         d4_m2_ff  <= mul_pp(d3_m1_ff, ps_ff[3]);
         w2s_ff[4] <= asr64(d3_w_ff, 19);
         p_ff[4]   <= p_ff[3];
         d5_m2_ff  <= mul_sum(d4_m2_ff);
         w2s_ff[5] <= w2s_ff[4];
         p_ff[5]   <= p_ff[4];
         d6_sum_ff <= p_ff[5] + asr64(d5_m2_ff, 25) + w2s_ff[5];
         for (int k = 2; k <= 6; k++) begin
            pside_ff[k] <= pside_ff[k-1];
         end
         // Result register.
         rsp_temp_ff  <= pside_ff[6].temp;
         rsp_fine_ff  <= pside_ff[6].fine;
         rsp_zero_ff  <= pside_ff[6].zero;
         rsp_press_ff <= pside_ff[6].zero ? 32'd0 : pout_w[31:0];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = rsp_temp_ff;
   assign rsp_fine_temperature  = rsp_fine_ff;
   assign rsp_pressure_q24_8    = rsp_press_ff;
   assign rsp_divisor_zero      = rsp_zero_ff;

`ifndef SYNTH
   // A zero divisor always forces the pressure to zero.
   a_zero_press : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divisor_zero |-> rsp_pressure_q24_8 == 32'd0)
      else $error("pressure not zero with zero divisor");

   // The input side only stalls behind a held result.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled without a held result");

   // Temperature and fine temperature stay aligned through the pipeline.
   a_temp_align : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temperature_centi ==
         asr32(rsp_fine_temperature * 32'd5 + ROUND_HALF, 8))
      else $error("temperature out of step with fine temperature");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

[sim/barometer_raw_compensation_tb.sv]
// Self-checking testbench for barometer_raw_compensation: random and directed readings
// under several trim settings, checked against an in-bench integer compensation model.
// Depends on barc_pkg and the barometer_raw_compensation RTL.
`timescale 1ns / 1ps

module barometer_raw_compensation_tb;
   import barc_pkg::*;

   // One expected result of the compensation.
   typedef struct {
      bit [31:0] temperature_centi;
      bit [31:0] pressure_q24_8;
      bit [31:0] fine_temperature;
      bit        divisor_zero;
   } reading_result_type;

   // Arithmetic right shift by sign replication, at both datapath widths.
   function automatic bit [63:0] sra64(bit [63:0] v, int n);
      return 64'({{64{v[63]}}, v} >> n);
   endfunction

   function automatic bit [31:0] sra32(bit [31:0] v, int n);
      return 32'({{32{v[31]}}, v} >> n);
   endfunction

   // Signed 16-bit trim word k of a packed register, widened to 64 bits.
   function automatic bit [63:0] trim_word(bit [47:0] v, int k);
      return {{48{v[16*k+15]}}, v[16*k +: 16]};
   endfunction

   // Holds a copy of the trim registers, the readings in flight and the
   // results they should produce, in acceptance order.
   class compensation_scoreboard;
      bit [47:0]          trim [4];
      reading_result_type pending [$];
      int                 errors;

      function void write_trim(csr_index_type idx, bit [47:0] value);
         trim[idx] = value;
      endfunction

      // Integer trimming formulas: 32-bit wrap on the temperature path,
      // 64-bit wrap on the pressure path, division truncating toward zero.
      function reading_result_type compensate(bit [19:0] raw_p, bit [19:0] raw_t);
         reading_result_type r;
         bit [31:0] t1, t2, t3, a, d, v1, v2, fine;
         bit [63:0] x, x2, w1, w2, dv, num, ma, mb, q, p;
         t1 = {16'd0, trim[CSR_TEMP][15:0]};
         t2 = {{16{trim[CSR_TEMP][31]}}, trim[CSR_TEMP][31:16]};
         t3 = {{16{trim[CSR_TEMP][47]}}, trim[CSR_TEMP][47:32]};
         a = (32'(raw_t) >> 3) - (t1 << 1);
         v1 = sra32(a * t2, 11);
         d = (32'(raw_t) >> 4) - t1;
         v2 = sra32(sra32(d * d, 12) * t3, 14);
         fine = v1 + v2;
         r.fine_temperature = fine;
         r.temperature_centi = sra32(fine * 32'd5 + 32'd128, 8);

         x = {{32{fine[31]}}, fine} - 64'd128000;
         x2 = x * x;
         w2 = x2 * trim_word(trim[CSR_PRESS_B], 2)
              + ((x * trim_word(trim[CSR_PRESS_B], 1)) << 17)
              + (trim_word(trim[CSR_PRESS_B], 0) << 35);
         w1 = sra64(x2 * trim_word(trim[CSR_PRESS_A], 2), 8)
              + ((x * trim_word(trim[CSR_PRESS_A], 1)) << 12);
         dv = sra64(((64'd1 << 47) + w1) * {48'd0, trim[CSR_PRESS_A][15:0]}, 33);

         r.divisor_zero = (dv == 64'd0);
         if (r.divisor_zero) begin
            p = 64'd0;
         end else begin
            p = 64'd1048576 - 64'(raw_p);
            num = ((p << 31) - w2) * 64'd3125;
            ma = num[63] ? -num : num;
            mb = dv[63] ? -dv : dv;
            q = ma / mb;
            if (num[63] != dv[63]) begin
               q = -q;
            end
            w1 = sra64(trim_word(trim[CSR_PRESS_C], 2) * sra64(q, 13) * sra64(q, 13), 25);
            w2 = sra64(trim_word(trim[CSR_PRESS_C], 1) * q, 19);
            p = sra64(q + w1 + w2, 8) + (trim_word(trim[CSR_PRESS_C], 0) << 4);
         end
         r.pressure_q24_8 = p[31:0];
         return r;
      endfunction

      function void note_reading(bit [19:0] raw_p, bit [19:0] raw_t);
         pending.push_back(compensate(raw_p, raw_t));
      endfunction

      function void check_result(logic [31:0] temp, logic [31:0] press,
                                 logic [31:0] fine, logic zero);
         reading_result_type e;
         if (pending.size() == 0) begin
            $error("result arrived with no reading outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (temp !== e.temperature_centi) begin
            $error("temperature_centi expected %h actual %h", e.temperature_centi, temp);
            errors++;
         end
         if (press !== e.pressure_q24_8) begin
            $error("pressure_q24_8 expected %h actual %h", e.pressure_q24_8, press);
            errors++;
         end
         if (fine !== e.fine_temperature) begin
            $error("fine_temperature expected %h actual %h", e.fine_temperature, fine);
            errors++;
         end
         if (zero !== e.divisor_zero) begin
            $error("divisor_zero expected %b actual %b", e.divisor_zero, zero);
            errors++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   logic [47:0]   csr_write_data;
   logic          req_valid;
   logic          req_stall;
   logic [19:0]   req_raw_pressure;
   logic [19:0]   req_raw_temperature;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [31:0]   rsp_temperature_centi;
   logic [31:0]   rsp_pressure_q24_8;
   logic [31:0]   rsp_fine_temperature;
   logic          rsp_divisor_zero;

   compensation_scoreboard sb;
   bit                     long_hold_request;

   barometer_raw_compensation dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_raw_pressure      (req_raw_pressure),
      .req_raw_temperature   (req_raw_temperature),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_q24_8    (rsp_pressure_q24_8),
      .rsp_fine_temperature  (rsp_fine_temperature),
      .rsp_divisor_zero      (rsp_divisor_zero)
   );

   always #5 clock = ~clock;

   // Inputs change only at rising edges, so the falling edge sees settled
   // handshakes. An item seen as valid and not stalled here is transferred at
   // the next rising edge, which makes the falling edge a race-free place to
   // record both accepted readings and accepted results.
   always @(negedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_reading(req_raw_pressure, req_raw_temperature);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_temperature_centi, rsp_pressure_q24_8,
                         rsp_fine_temperature, rsp_divisor_zero);
      end
   end

   // Result-side back-pressure. Segments alternate between free flow, random
   // stalls and a fixed stall cadence. When a long hold is requested the
   // receiver stalls for longer than the pipeline is deep, so the pipeline
   // fills and the input side must stall as well.
   initial begin
      int mode;
      int span;
      @(negedge reset);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 0;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(1, 60);
            for (int i = 0; i < span; i++) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 1) == 1);
                  default: rsp_stall <= (i % 3 == 2);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Presents one reading and returns at the rising edge that takes it. The
   // valid stays high, so back-to-back calls form a burst without a gap.
   task automatic send_reading(bit [19:0] raw_p, bit [19:0] raw_t);
      req_valid <= 1'b1;
      req_raw_pressure <= raw_p;
      req_raw_temperature <= raw_t;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   // Random readings in bursts of random length separated by random gaps.
   task automatic send_random_readings(int count);
      int burst_left;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
         send_reading(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)));
      end
      req_valid <= 1'b0;
   endtask

   // Lets the pipeline empty so that the trim registers may be rewritten.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (90) @(posedge clock);
   endtask

   task automatic write_trim(csr_index_type idx, bit [47:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      sb.write_trim(idx, value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_trims(bit [47:0] temp, bit [47:0] pa, bit [47:0] pb, bit [47:0] pc);
      write_trim(CSR_TEMP, temp);
      write_trim(CSR_PRESS_A, pa);
      write_trim(CSR_PRESS_B, pb);
      write_trim(CSR_PRESS_C, pc);
   endtask

   function automatic bit [47:0] random_trim();
      return 48'({$urandom, $urandom});
   endfunction

   // Typical trim words: T1..T3 and P1..P9 of a calibrated sensor.
   localparam bit [47:0] TYP_TEMP = {16'hFC18, 16'd26435, 16'd27504};
   localparam bit [47:0] TYP_PA   = {16'd3024, 16'hD643, 16'd36477};
   localparam bit [47:0] TYP_PB   = {16'hFFF9, 16'd140, 16'd2855};
   localparam bit [47:0] TYP_PC   = {16'd6000, 16'hC6F8, 16'd15500};

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_TEMP;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_raw_pressure = '0;
      req_raw_temperature = '0;
      rsp_stall = 1'b0;
      long_hold_request = 0;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers still at reset: P1 is zero, so every divisor is zero.
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_random_readings(10);
      wait_until_drained();

      // Typical calibration: raw extremes and realistic readings first.
      load_trims(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC);
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'd0, 20'hFFFFF);
      send_reading(20'hFFFFF, 20'd0);
      send_reading(20'hAAAAA, 20'h55555);
      send_reading(20'h55555, 20'hAAAAA);
      send_reading(20'd415148, 20'd519888);
      send_reading(20'd300000, 20'd440000);
      send_reading(20'd600000, 20'd560000);
      req_valid <= 1'b0;
      // The receiver goes quiet for a long stretch while readings keep coming.
      long_hold_request = 1;
      send_random_readings(280);
      wait_until_drained();

      // Every trim bit set.
      load_trims('1, '1, '1, '1);
      send_random_readings(50);
      wait_until_drained();

      // Signed lanes at their most negative, unsigned words at mid-scale.
      load_trims(48'h8000_8000_8000, 48'h8000_8000_8000,
                 48'h8000_8000_8000, 48'h8000_8000_8000);
      send_random_readings(30);
      wait_until_drained();

      // Signed lanes at their most positive, unsigned words at full scale.
      load_trims(48'h7FFF_7FFF_FFFF, 48'h7FFF_7FFF_FFFF,
                 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
      send_random_readings(30);
      wait_until_drained();

      // Fully random trim words, changed a few times.
      for (int k = 0; k < 4; k++) begin
         load_trims(random_trim(), random_trim(), random_trim(), random_trim());
         send_random_readings(25);
         wait_until_drained();
      end

      // Back to zero everywhere written explicitly.
      load_trims('0, '0, '0, '0);
      send_random_readings(20);
      wait_until_drained();

      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
